/* hdl/lurt_pkg.sv */
package lurt_pkg;

  // table size and index widths
  localparam int unsigned ALPHABET  = 256;
  localparam int unsigned CODE_BITS = $clog2(ALPHABET);
  localparam int unsigned POS_BITS  = 16;
  localparam int unsigned LEN_BITS  = 16;
  localparam int unsigned CHAR_BITS = 8;

  localparam logic [POS_BITS-1:0] POS_LIMIT = {POS_BITS{1'b1}};

  typedef logic [POS_BITS-1:0]  pos_t;
  typedef logic [CODE_BITS-1:0] code_t;

  // one byte of the stream
  typedef struct packed {
    logic                 first;
    logic [CHAR_BITS-1:0] char_code;
  } in_item_t;

  // one result per byte
  typedef struct packed {
    logic [LEN_BITS-1:0] current_length;
    logic [LEN_BITS-1:0] max_length;
    logic                overflow;
  } out_item_t;

endpackage

/* hdl/lurt_if.sv */
interface lurt_in_if;
  import lurt_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface lurt_out_if;
  import lurt_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

/* hdl/lurt_ram.sv */
module lurt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port, read returns old data on collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/longest_unique_run_tracker.sv */
// Tracks the longest run of bytes with no repeated code in a byte stream. One byte is
// taken per item and each byte gives one result: the length of the repeat-free window
// that ends at it, the best length in the current string, and an overflow flag. A set
// first bit starts a new string; all 256 codes are data. The block takes one item every
// cycle while the output is not stalled; the table read registers at the edge that takes
// it, then the update lands in the output register; the rate is set by the last-position
// table, which is read once and written at most once per item, with forwarding between
// neighboring items. Once a string reaches 65535 bytes, further bytes are not tracked,
// overflow reads 1 and the lengths hold until the next first bit. The seen bits are
// flip-flops that reset to zero and all clear on a first bit, so there is no clearing
// pass after reset.
module longest_unique_run_tracker (
  input logic      clk_i,
  input logic      rst_ni,
  lurt_in_if.sink  in_i,
  lurt_out_if.source out_o
);
  import lurt_pkg::*;

  // update stage
  logic         s1_valid_q;
  logic         s1_first_q;
  code_t        s1_code_q;
  logic         s1_adv;
  logic         in_fire;

  // forwarding of the write made in the cycle of the table read
  logic         fwd_hit_q, fwd_hit_d;
  pos_t         fwd_pos_q;

  // string state
  logic [ALPHABET-1:0] seen_q, seen_d;
  pos_t         ws_q, ws_d;
  pos_t         pos_q, pos_d;
  pos_t         best_q, best_d;
  logic         ovf_q, ovf_d;

  // output register
  logic         out_valid_q;
  out_item_t    out_item_q, out_item_d;

  // table port
  logic         tbl_we;
  pos_t         tbl_rdata;
  pos_t         last_pos;
  code_t        in_code;

  // working values
  pos_t         ws_e, pos_e, best_e, cur;
  logic         ovf_e, seen_e;

  assign in_code  = in_i.item.char_code[CODE_BITS-1:0];
  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire  = in_i.valid && in_i.ready;
  assign tbl_we   = s1_adv && !ovf_d;

  lurt_ram #(
    .WIDTH (POS_BITS),
    .DEPTH (ALPHABET)
  ) u_last_pos (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (s1_code_q),
    .wdata_i (pos_e),
    .re_i    (in_fire),
    .raddr_i (in_code),
    .rdata_o (tbl_rdata)
  );

  assign fwd_hit_d = tbl_we && (s1_code_q == in_code);
  assign last_pos  = fwd_hit_q ? fwd_pos_q : tbl_rdata;

  // window update for the byte in the update stage
  always_comb begin
    ws_e   = s1_first_q ? '0 : ws_q;
    pos_e  = s1_first_q ? '0 : pos_q;
    best_e = s1_first_q ? '0 : best_q;
    ovf_e  = s1_first_q ? 1'b0 : ovf_q;
    seen_e = seen_q[s1_code_q] && !s1_first_q;

    seen_d = s1_first_q ? '0 : seen_q;
    ovf_d  = ovf_e || (pos_e == POS_LIMIT);
    ws_d   = ws_e;
    pos_d  = pos_e;
    if (!ovf_d) begin
      if (seen_e && (last_pos >= ws_e)) begin
        ws_d = last_pos + 1'b1;
      end
      seen_d[s1_code_q] = 1'b1;
      pos_d = pos_e + 1'b1;
    end

    cur    = pos_d - ws_d;
    best_d = best_e;
    if (!ovf_d && (cur > best_e)) begin
      best_d = cur;
    end

    out_item_d.current_length = cur;
    out_item_d.max_length     = best_d;
    out_item_d.overflow       = ovf_d;
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      seen_q      <= '0;
      ws_q        <= '0;
      pos_q       <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_fire;
      end
      if (in_fire) begin
        fwd_hit_q <= fwd_hit_d;
      end
      if (s1_adv) begin
        seen_q <= seen_d;
        ws_q   <= ws_d;
        pos_q  <= pos_d;
        best_q <= best_d;
        ovf_q  <= ovf_d;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_first_q <= in_i.item.first;
      s1_code_q  <= in_code;
      fwd_pos_q  <= pos_e;
    end
    if (s1_adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  // window start never passes the position
  a_ws_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ws_q <= pos_q)
    else $error("window start beyond position");

  // best length covers the current window
  a_best_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q >= pos_q - ws_q)
    else $error("best length below current window");

  // state holds once overflowed, until a new string
  a_ovf_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && ovf_q && !s1_first_q |=> $stable(pos_q) && $stable(ws_q) && $stable(best_q))
    else $error("state moved after overflow");

  // a taken item reaches the update stage in the next cycle
  a_fire_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted item lost");

endmodule
